@@ hw/rtl/bgce_pkg.sv @@
// ----------------------------------------------------------------------------
// bgce_pkg
// shared constants and types for the button grid change event block
// ----------------------------------------------------------------------------
package bgce_pkg;

  localparam int unsigned DEF_HW_COLUMNS   = 16;
  localparam int unsigned DEF_PHYS_COLUMNS = 8;
  localparam int unsigned DEF_ROWS         = 4;

  localparam int unsigned COL_W  = 4;
  localparam int unsigned SMP_W  = 4;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned ROW_IW = 2;

  localparam logic [SMP_W-1:0] SAMPLE_MASK = 4'hF;

  // work handed from the change detector to the event serializer
  typedef struct packed {
    logic             valid;
    logic [SMP_W-1:0] changes;
    logic [SMP_W-1:0] cur;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] y_ofs;
  } ev_load_t;

endpackage

@@ hw/rtl/button_grid_change_events.sv @@
// ----------------------------------------------------------------------------
// button_grid_change_events
// turns stable column scans of a button matrix into per-button change events
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                         | tlast
//  s_axis  | in  | column[3:0] current_rows[7:4] prev[11:8]   | -
//  m_axis  | out | level[0] pos_x[3:1] pos_y[6:4], pad[7]     | last event of column
//
//  an accepted scan is held in the input register and checked there, then
//  either dropped or, once the serializer is free, handed to it. a column
//  with changed rows keeps the serializer busy until every event is sent,
//  one event per cycle into the output register while the output does not
//  stall. reset clears the row state of every column and empties all stages.
//  output stalls back up through the serializer into the input register.
// ----------------------------------------------------------------------------
module button_grid_change_events import bgce_pkg::*; #(
  parameter int unsigned HW_COLUMNS   = DEF_HW_COLUMNS,
  parameter int unsigned PHYS_COLUMNS = DEF_PHYS_COLUMNS,
  parameter int unsigned ROWS         = DEF_ROWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // column, current_rows, previous_rows
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // level, pos_x, pos_y
  output logic        m_axis_tlast_o
);

  logic             in_valid_q;
  logic [COL_W-1:0] column_q;
  logic [SMP_W-1:0] cur_q;
  logic [SMP_W-1:0] prev_q;

  logic             take;
  logic             ser_free;
  ev_load_t         load;
  logic             level;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;

  assign s_axis_tready_o = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      column_q <= s_axis_tdata_i[3:0];
      cur_q    <= s_axis_tdata_i[7:4];
      prev_q   <= s_axis_tdata_i[11:8];
    end
  end

  bgce_detect #(
    .HW_COLUMNS   (HW_COLUMNS),
    .PHYS_COLUMNS (PHYS_COLUMNS),
    .ROWS         (ROWS)
  ) u_detect (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (in_valid_q),
    .column_i        (column_q),
    .current_rows_i  (cur_q),
    .previous_rows_i (prev_q),
    .ser_free_i      (ser_free),
    .take_o          (take),
    .load_o          (load)
  );

  bgce_serializer u_ser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .ser_free_o (ser_free),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_level_o  (level),
    .m_pos_x_o  (pos_x),
    .m_pos_y_o  (pos_y),
    .m_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, pos_y, pos_x, level};

endmodule

@@ hw/rtl/bgce_detect.sv @@
// ----------------------------------------------------------------------------
// bgce_detect
// per-column row state, stability test and change detection
// ----------------------------------------------------------------------------
module bgce_detect import bgce_pkg::*; #(
  parameter int unsigned HW_COLUMNS   = DEF_HW_COLUMNS,
  parameter int unsigned PHYS_COLUMNS = DEF_PHYS_COLUMNS,
  parameter int unsigned ROWS         = DEF_ROWS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  logic [COL_W-1:0] column_i,
  input  logic [SMP_W-1:0] current_rows_i,
  input  logic [SMP_W-1:0] previous_rows_i,
  input  logic             ser_free_i,
  output logic             take_o,
  output ev_load_t         load_o
);

  localparam int unsigned DEPTH = (HW_COLUMNS < 16) ? HW_COLUMNS : 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [SMP_W-1:0] ROW_MASK =
    (ROWS >= SMP_W) ? SAMPLE_MASK : SMP_W'((1 << ROWS) - 1);
  localparam logic [POS_W-1:0] ROW_OFS = POS_W'(ROWS);

  logic [SMP_W-1:0] rows_q [DEPTH];

  logic             in_range;
  logic [IDX_W-1:0] idx;
  logic [SMP_W-1:0] stored;
  logic [SMP_W-1:0] changes;
  logic             stable;
  logic             drop;
  logic             fold;

  always_comb begin
    in_range = (32'(column_i) < DEPTH);
    idx      = IDX_W'(column_i);
    stored   = in_range ? rows_q[idx] : '0;
    changes  = (current_rows_i ^ stored) & ROW_MASK;
    stable   = ((current_rows_i ^ previous_rows_i) & ROW_MASK) == '0;
    drop     = !in_range || !stable || (changes == '0);
    fold     = (32'(column_i) >= PHYS_COLUMNS);

    take_o          = item_valid_i && (drop || ser_free_i);
    load_o.valid    = item_valid_i && !drop && ser_free_i;
    load_o.changes  = changes;
    load_o.cur      = current_rows_i;
    load_o.pos_x    = fold ? POS_W'(32'(column_i) - PHYS_COLUMNS) : POS_W'(column_i);
    load_o.y_ofs    = fold ? ROW_OFS : '0;
  end

  // each event flips its bit, so the entry ends up at the current sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        rows_q[i] <= '0;
      end
    end else if (load_o.valid) begin
      rows_q[idx] <= stored ^ changes;
    end
  end

endmodule

@@ hw/rtl/bgce_serializer.sv @@
// ----------------------------------------------------------------------------
// bgce_serializer
// emits one event per cycle while the output does not stall, from a pending change mask, lowest row first
// ----------------------------------------------------------------------------
module bgce_serializer import bgce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ev_load_t   load_i,
  output logic       ser_free_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic       m_level_o,
  output logic [POS_W-1:0] m_pos_x_o,
  output logic [POS_W-1:0] m_pos_y_o,
  output logic       m_last_o
);

  logic [SMP_W-1:0] pend_q, pend_d;
  logic [SMP_W-1:0] cur_q;
  logic [POS_W-1:0] pos_x_q;
  logic [POS_W-1:0] y_ofs_q;
  logic             m_valid_q;
  logic             level_q;
  logic [POS_W-1:0] pos_x_out_q;
  logic [POS_W-1:0] pos_y_q;
  logic             last_q;

  logic             out_free;
  logic             emit;
  logic [SMP_W-1:0] low;
  logic             is_last;
  logic [ROW_IW-1:0] row;

  always_comb begin
    out_free = !m_valid_q || m_ready_i;
    emit     = (pend_q != '0) && out_free;
    low      = pend_q & (~pend_q + SMP_W'(1));
    is_last  = (pend_q & ~low) == '0;
    row      = '0;
    for (int y = SMP_W - 1; y >= 0; y--) begin
      if (pend_q[y]) begin
        row = ROW_IW'(y);
      end
    end
    ser_free_o = (pend_q == '0) || (emit && is_last);
    pend_d = pend_q;
    if (emit) begin
      pend_d = pend_q & ~low;
    end
    if (load_i.valid) begin
      pend_d = load_i.changes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (emit) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.valid) begin
      cur_q   <= load_i.cur;
      pos_x_q <= load_i.pos_x;
      y_ofs_q <= load_i.y_ofs;
    end
    if (emit) begin
      level_q     <= cur_q[row];
      pos_x_out_q <= pos_x_q;
      pos_y_q     <= POS_W'(row) + y_ofs_q;
      last_q      <= is_last;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_level_o = level_q;
  assign m_pos_x_o = pos_x_out_q;
  assign m_pos_y_o = pos_y_q;
  assign m_last_o  = last_q;

  // a new column only lands once the previous one is fully drained
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.valid |-> (pend_q == '0) || (emit && is_last))
    else $error("column loaded over pending events");

  a_load_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.valid |-> load_i.changes != '0)
    else $error("column loaded with no changes");

  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && is_last && !load_i.valid |=> pend_q == '0)
    else $error("pending mask not empty after last event");

  a_emit_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> m_valid_q)
    else $error("event emitted but output register empty");

endmodule
